// ===== rtl/core/cdm_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the
// concentric square-to-disk map. No dependencies.
package cdm_pkg;

  localparam int DIV_STEPS        = 17;
  localparam int DIV_PER_STAGE    = 2;
  localparam int DIV_STAGES       = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int CORDIC_STEPS     = 16;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;

  localparam logic [15:0] CORDIC_GAIN = 16'd39797;
  localparam logic [7:0]  NZ_RESET    = 8'd1;

  localparam logic [1:0] SECT_1 = 2'd0;
  localparam logic [1:0] SECT_2 = 2'd1;
  localparam logic [1:0] SECT_3 = 2'd2;
  localparam logic [1:0] SECT_4 = 2'd3;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [1:0]  sect;
    logic        neg;
    logic        zero;
    logic [16:0] rad;
    logic        last;
  } side_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    begin
      unique case (i)
        0:  a = 32'h20000000;
        1:  a = 32'h12E4051D;
        2:  a = 32'h09FB385B;
        3:  a = 32'h051111D4;
        4:  a = 32'h028B0D43;
        5:  a = 32'h0145D7E1;
        6:  a = 32'h00A2F61E;
        7:  a = 32'h00517C55;
        8:  a = 32'h0028BE53;
        9:  a = 32'h00145F2E;
        10: a = 32'h000A2F98;
        11: a = 32'h000517CC;
        12: a = 32'h00028BE6;
        13: a = 32'h000145F3;
        14: a = 32'h0000A2F9;
        default: a = 32'h0000517C;
      endcase
      return a;
    end
  endfunction

endpackage

// ===== rtl/core/cdm_sector.sv =====
// Front stage: recenters the sample, picks the sector, forms the ratio
// operands as magnitudes. Depends on cdm_pkg.
module cdm_sector (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid,
  input  logic [15:0]         sample_u,
  input  logic [15:0]         sample_v,
  input  logic                last_in,
  input  logic [7:0]          limit,
  output logic                o_valid,
  output logic [16:0]         o_num,
  output logic [16:0]         o_den,
  output cdm_pkg::side_t      o_side
);

  logic signed [16:0] xs, ys, nx, ny, n, d;
  logic [16:0] num_abs, den_abs;
  cdm_pkg::side_t side;

  always_comb begin
    xs = {~sample_u[15], ~sample_u[15], sample_u[14:0]};
    ys = {~sample_v[15], ~sample_v[15], sample_v[14:0]};
    nx = -xs;
    ny = -ys;
    side.last = last_in;
    side.zero = 1'b0;
    if (xs > ny) begin
      if (xs > ys) begin
        side.sect = cdm_pkg::SECT_1;
        side.rad  = xs;
        n = ys;
        d = xs;
      end else begin
        side.sect = cdm_pkg::SECT_2;
        side.rad  = ys;
        n = xs;
        d = ys;
      end
    end else begin
      if (xs < ys) begin
        side.sect = cdm_pkg::SECT_3;
        side.rad  = nx;
        n = ys;
        d = xs;
      end else begin
        side.sect = cdm_pkg::SECT_4;
        side.rad  = ny;
        n = xs;
        d = ys;
        side.zero = (ny <= $signed({9'd0, limit}));
      end
    end
    side.neg = n[16] ^ d[16];
    num_abs  = n[16] ? 17'(-n) : 17'(n);
    den_abs  = d[16] ? 17'(-d) : 17'(d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_num  <= num_abs;
      o_den  <= den_abs;
      o_side <= side;
    end
  end

endmodule

// ===== rtl/core/cdm_divider.sv =====
// Pipelined restoring divider: floor(num * 2^16 / den), num <= den,
// two quotient bits per stage. Depends on cdm_pkg.
module cdm_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           valid,
  input  logic [16:0]    num,
  input  logic [16:0]    den,
  input  cdm_pkg::side_t side,
  output logic           o_valid,
  output logic [16:0]    o_quot,
  output cdm_pkg::side_t o_side
);

  localparam int NS = cdm_pkg::DIV_STAGES;

  logic [17:0]    rem_a  [NS+1];
  logic [16:0]    quot_a [NS+1];
  logic [16:0]    den_a  [NS+1];
  cdm_pkg::side_t side_a [NS+1];
  logic           vld_a  [NS+1];

  assign rem_a[0]  = {1'b0, num};
  assign quot_a[0] = '0;
  assign den_a[0]  = den;
  assign side_a[0] = side;
  assign vld_a[0]  = valid;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [17:0] rem_next;
    logic [16:0] quot_next;

    always_comb begin
      rem_next  = rem_a[s];
      quot_next = quot_a[s];
      for (int k = 0; k < cdm_pkg::DIV_PER_STAGE; k++) begin
        if (s * cdm_pkg::DIV_PER_STAGE + k < cdm_pkg::DIV_STEPS) begin
          if (s * cdm_pkg::DIV_PER_STAGE + k != 0) begin
            rem_next = {rem_next[16:0], 1'b0};
          end
          if (rem_next >= {1'b0, den_a[s]}) begin
            rem_next  = rem_next - {1'b0, den_a[s]};
            quot_next = {quot_next[15:0], 1'b1};
          end else begin
            quot_next = {quot_next[15:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_a[s+1] <= 1'b0;
      end else if (en) begin
        vld_a[s+1] <= vld_a[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[s+1]  <= rem_next;
        quot_a[s+1] <= quot_next;
        den_a[s+1]  <= den_a[s];
        side_a[s+1] <= side_a[s];
      end
    end
  end

  assign o_valid = vld_a[NS];
  assign o_quot  = quot_a[NS];
  assign o_side  = side_a[NS];

endmodule

// ===== rtl/core/cdm_cordic.sv =====
// Gain-scaling multiply and pipelined rotation-mode CORDIC, two
// iterations per stage. Depends on cdm_pkg.
module cdm_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid,
  input  logic [16:0]        rad,
  input  logic signed [31:0] ang,
  input  logic [1:0]         quad,
  input  logic               last,
  output logic               o_valid,
  output logic signed [33:0] o_x,
  output logic signed [33:0] o_y,
  output logic [1:0]         o_quad,
  output logic               o_last
);

  localparam int NS = cdm_pkg::CORDIC_STAGES;

  logic signed [33:0] x_a [NS+1];
  logic signed [33:0] y_a [NS+1];
  logic signed [31:0] z_a [NS+1];
  logic [1:0]         q_a [NS+1];
  logic               l_a [NS+1];
  logic               v_a [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a[0] <= 1'b0;
    end else if (en) begin
      v_a[0] <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a[0] <= 34'($unsigned(rad) * $unsigned(cdm_pkg::CORDIC_GAIN));
      y_a[0] <= '0;
      z_a[0] <= ang;
      q_a[0] <= quad;
      l_a[0] <= last;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic signed [33:0] x_next, y_next, dx, dy;
    logic signed [31:0] z_next;

    always_comb begin
      x_next = x_a[s];
      y_next = y_a[s];
      z_next = z_a[s];
      dx = '0;
      dy = '0;
      for (int k = 0; k < cdm_pkg::CORDIC_PER_STAGE; k++) begin
        dx = y_next >>> (s * cdm_pkg::CORDIC_PER_STAGE + k);
        dy = x_next >>> (s * cdm_pkg::CORDIC_PER_STAGE + k);
        if (!z_next[31]) begin
          x_next = x_next - dx;
          y_next = y_next + dy;
          z_next = z_next - $signed(cdm_pkg::atan_turn(s * cdm_pkg::CORDIC_PER_STAGE + k));
        end else begin
          x_next = x_next + dx;
          y_next = y_next - dy;
          z_next = z_next + $signed(cdm_pkg::atan_turn(s * cdm_pkg::CORDIC_PER_STAGE + k));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[s+1] <= 1'b0;
      end else if (en) begin
        v_a[s+1] <= v_a[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_a[s+1] <= x_next;
        y_a[s+1] <= y_next;
        z_a[s+1] <= z_next;
        q_a[s+1] <= q_a[s];
        l_a[s+1] <= l_a[s];
      end
    end
  end

  assign o_valid = v_a[NS];
  assign o_x     = x_a[NS];
  assign o_y     = y_a[NS];
  assign o_quad  = q_a[NS];
  assign o_last  = l_a[NS];

endmodule

// ===== rtl/core/concentric_square_to_disk_map.sv =====
// Concentric square-to-disk map, top level. Uses cdm_pkg, cdm_sector,
// cdm_divider and cdm_cordic.
// Registered stages in order: sector, divider, angle, gain multiply,
// CORDIC, output. Throughput: one beat per cycle; the whole pipeline
// holds while a finished beat waits at the output.
// Reset clears all stage valid bits and sets near_zero_limit to 1.
module concentric_square_to_disk_map (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        sample_u,
  input  logic [15:0]        sample_v,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] disk_x,
  output logic signed [15:0] disk_y,
  output logic               last_out,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  logic [7:0] near_zero_limit;
  logic       en;

  logic           s0_valid;
  logic [16:0]    s0_num, s0_den;
  cdm_pkg::side_t s0_side;

  logic           dv_valid;
  logic [16:0]    dv_quot;
  cdm_pkg::side_t dv_side;

  logic [18:0]        t19, base19, a19;
  logic [31:0]        dsum;
  logic               an_valid, an_last;
  logic signed [31:0] an_z;
  logic [1:0]         an_quad;
  logic [16:0]        an_rad;

  logic               cr_valid, cr_last;
  logic signed [33:0] cr_x, cr_y, rx, ry;
  logic [1:0]         cr_quad;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= cdm_pkg::NZ_RESET;
    end else if (cfg_wr_en) begin
      near_zero_limit <= cfg_wr_data;
    end
  end

  cdm_sector u_sector (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid    (in_valid),
    .sample_u (sample_u),
    .sample_v (sample_v),
    .last_in  (last_in),
    .limit    (near_zero_limit),
    .o_valid  (s0_valid),
    .o_num    (s0_num),
    .o_den    (s0_den),
    .o_side   (s0_side)
  );

  cdm_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid   (s0_valid),
    .num     (s0_num),
    .den     (s0_den),
    .side    (s0_side),
    .o_valid (dv_valid),
    .o_quot  (dv_quot),
    .o_side  (dv_side)
  );

  // angle in eighths, modulo 2^19 is all that survives the shift into turns
  always_comb begin
    t19    = dv_side.neg ? 19'(-{2'b00, dv_quot}) : {2'b00, dv_quot};
    base19 = '0;
    a19    = '0;
    unique case (dv_side.sect)
      cdm_pkg::SECT_1: a19 = t19;
      cdm_pkg::SECT_2: begin
        base19 = 19'd131072;
        a19    = base19 - t19;
      end
      cdm_pkg::SECT_3: begin
        base19 = 19'd262144;
        a19    = base19 + t19;
      end
      default: begin
        base19 = 19'd393216;
        a19    = dv_side.zero ? 19'd0 : base19 - t19;
      end
    endcase
    dsum = {a19, 13'd0} + 32'h2000_0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      an_valid <= 1'b0;
    end else if (en) begin
      an_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an_z    <= $signed({2'b00, dsum[29:0]}) - 32'sh2000_0000;
      an_quad <= dsum[31:30];
      an_rad  <= dv_side.rad;
      an_last <= dv_side.last;
    end
  end

  cdm_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid   (an_valid),
    .rad     (an_rad),
    .ang     (an_z),
    .quad    (an_quad),
    .last    (an_last),
    .o_valid (cr_valid),
    .o_x     (cr_x),
    .o_y     (cr_y),
    .o_quad  (cr_quad),
    .o_last  (cr_last)
  );

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] s;
    logic signed [17:0] q;
    begin
      s = (v + 34'sd32768) >>> 16;
      q = s[17:0];
      if (q > 18'sd32767) begin
        return 16'sh7FFF;
      end else if (q < -18'sd32768) begin
        return 16'sh8000;
      end
      return q[15:0];
    end
  endfunction

  always_comb begin
    unique case (cr_quad)
      cdm_pkg::QUAD_1: begin
        rx = -cr_y;
        ry = cr_x;
      end
      cdm_pkg::QUAD_2: begin
        rx = -cr_x;
        ry = -cr_y;
      end
      cdm_pkg::QUAD_3: begin
        rx = cr_y;
        ry = -cr_x;
      end
      default: begin
        rx = cr_x;
        ry = cr_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disk_x   <= to_q15(rx);
      disk_y   <= to_q15(ry);
      last_out <= cr_last;
    end
  end

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output beat");

  a_limit_rst: assert property (@(posedge clk)
    rst |=> near_zero_limit == cdm_pkg::NZ_RESET)
    else $error("near_zero_limit not at reset value");

  a_zero_sect: assert property (@(posedge clk) disable iff (rst)
    (s0_valid && s0_side.zero) |-> s0_side.sect == cdm_pkg::SECT_4)
    else $error("zero-angle flag outside the fourth sector");

endmodule
